// ===== rtl/core/sta_pkg.sv =====
package sta_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BASE    = 3'd0,
        REG_RANK    = 3'd1,
        REG_SIZES   = 3'd2,
        REG_STR01   = 3'd3,
        REG_STR23   = 3'd4
    } reg_idx_t;

    localparam int IDX_BITS  = 32;
    localparam int ADDR_BITS = 32;
    localparam int REG_BITS  = 48;

endpackage

// ===== rtl/core/sta_divstage.sv =====
// One dimension of the address walk: a pipelined restoring divider that
// retires one quotient bit per stage, then a multiply-accumulate stage.
// Every item carries its own size, stride and valid bit, so a new item
// may enter in every cycle.
module sta_divstage #(
    parameter int DIM_BITS    = 12,
    parameter int STRIDE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_active,
    input  logic [sta_pkg::IDX_BITS-1:0]  in_rest,
    input  logic [sta_pkg::ADDR_BITS-1:0] in_addr,
    input  logic                          in_bad,
    input  logic [DIM_BITS-1:0]           in_size,
    input  logic [STRIDE_BITS-1:0]        in_stride,
    output logic                          out_valid,
    output logic [sta_pkg::IDX_BITS-1:0]  out_rest,
    output logic [sta_pkg::ADDR_BITS-1:0] out_addr,
    output logic                          out_bad
);

    localparam int NB = sta_pkg::IDX_BITS;
    localparam int NS = NB + 1;

    typedef struct packed {
        logic                          active;
        logic                          bad;
        logic [DIM_BITS-1:0]           size;
        logic [STRIDE_BITS-1:0]        stride;
        logic [sta_pkg::ADDR_BITS-1:0] addr;
    } ctl_t;

    logic                          v_reg   [NS];
    ctl_t                          c_reg   [NS];
    logic [NB-1:0]                 q_reg   [NS];
    logic [DIM_BITS-1:0]           r_reg   [NS];

    logic                          mv_reg;
    logic [NB-1:0]                 mq_reg;
    logic [sta_pkg::ADDR_BITS-1:0] ma_reg;
    logic                          mb_reg;

    // Stage 0 captures the item; quotient register holds the dividend.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            mv_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            mv_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg[0].active <= in_active;
        c_reg[0].bad    <= in_bad || (in_active && (in_size == '0));
        c_reg[0].size   <= in_size;
        c_reg[0].stride <= in_stride;
        c_reg[0].addr   <= in_addr;
        q_reg[0]        <= in_rest;
        r_reg[0]        <= '0;
    end

    // One restoring division step per stage, most significant bit first.
    generate
        for (genvar s = 1; s < NS; s++)
        begin : g_step
            logic [DIM_BITS:0] trial;
            logic [DIM_BITS:0] diff;
            assign trial = {r_reg[s-1], q_reg[s-1][NB-1]};
            assign diff  = trial - {1'b0, c_reg[s-1].size};
            always_ff @(posedge clk)
            begin
                c_reg[s] <= c_reg[s-1];
                if (!diff[DIM_BITS])
                begin
                    r_reg[s] <= diff[DIM_BITS-1:0];
                    q_reg[s] <= {q_reg[s-1][NB-2:0], 1'b1};
                end
                else
                begin
                    r_reg[s] <= trial[DIM_BITS-1:0];
                    q_reg[s] <= {q_reg[s-1][NB-2:0], 1'b0};
                end
            end
        end
    endgenerate

    // Coordinate times sign-extended stride, added to the running address.
    logic [sta_pkg::ADDR_BITS-1:0] stride_ext;
    logic [sta_pkg::ADDR_BITS-1:0] prod;
    ctl_t                          cl;
    assign cl         = c_reg[NS-1];
    assign stride_ext = {{(sta_pkg::ADDR_BITS-STRIDE_BITS){cl.stride[STRIDE_BITS-1]}},
                         cl.stride};
    assign prod       = sta_pkg::ADDR_BITS'({{(sta_pkg::ADDR_BITS-DIM_BITS){1'b0}},
                                             r_reg[NS-1]} * stride_ext);

    always_ff @(posedge clk)
    begin
        if (cl.active && !cl.bad)
        begin
            mq_reg <= q_reg[NS-1];
            ma_reg <= cl.addr + prod;
        end
        else
        begin
            mq_reg <= q_reg[NS-1];
            ma_reg <= cl.addr;
        end
        mb_reg <= cl.bad;
    end

    // A zero size leaves the quotient as garbage; the bad flag masks it.
    always_comb
    begin
        out_valid = mv_reg;
        out_rest  = mq_reg;
        out_addr  = ma_reg;
        out_bad   = mb_reg;
    end

endmodule

// ===== rtl/core/strided_tensor_address_top.sv =====
// Strided tensor address generator.
// Pulse start with flat_index while busy is low; busy is never raised, so
// one item is taken in every cycle. Each item walks the dimensions from
// the innermost outward, one pipelined divider per dimension: an entry
// stage, 32 stages of one quotient bit each and a multiply-accumulate
// stage. Results appear in order with done high for one cycle, at one
// item per cycle, after passing the dimension units and an output register.
// element_address is base plus the sum of coordinate times stride
// modulo 2^32; bad_shape is set and the address is 0 when a dimension
// inside the rank has size zero.
// Reset clears the pipeline valid bits and all configuration registers.
// The receiver cannot stall; results must be taken when done is high.
// Configuration is written over the APB port at 8-byte spacing and must
// only be written while no item is in flight.
module strided_tensor_address_top #(
    parameter int MAX_RANK    = 4,
    parameter int DIM_BITS    = 12,
    parameter int STRIDE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] flat_index,
    output logic        done,
    output logic [31:0] element_address,
    output logic        bad_shape,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [31:0] base_reg;
    logic [2:0]  rank_reg;
    logic [47:0] sizes_reg;
    logic [47:0] str01_reg;
    logic [47:0] str23_reg;
    logic        wr;
    logic [2:0]  widx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr     = psel && penable && pwrite;
    assign widx   = paddr[5:3];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            rank_reg  <= '0;
            sizes_reg <= '0;
            str01_reg <= '0;
            str23_reg <= '0;
        end
        else if (wr && paddr[2:0] == 3'd0)
        begin
            case (widx)
                sta_pkg::REG_BASE:  base_reg  <= pwdata[31:0];
                sta_pkg::REG_RANK:  rank_reg  <= pwdata[2:0];
                sta_pkg::REG_SIZES: sizes_reg <= pwdata[47:0];
                sta_pkg::REG_STR01: str01_reg <= pwdata[47:0];
                sta_pkg::REG_STR23: str23_reg <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (widx)
            sta_pkg::REG_BASE:  prdata = {32'd0, base_reg};
            sta_pkg::REG_RANK:  prdata = {61'd0, rank_reg};
            sta_pkg::REG_SIZES: prdata = {16'd0, sizes_reg};
            sta_pkg::REG_STR01: prdata = {16'd0, str01_reg};
            sta_pkg::REG_STR23: prdata = {16'd0, str23_reg};
            default:            prdata = '0;
        endcase
    end

    // Per-dimension size and stride; missing bits read as zero.
    logic [DIM_BITS-1:0]    size_of   [MAX_RANK];
    logic [STRIDE_BITS-1:0] stride_of [MAX_RANK];
    logic [2:0]             rank_sat;
    logic [191:0]           strides_all;
    assign strides_all = {48'd0, str23_reg[47:0], 48'd0, str01_reg[47:0]};
    assign rank_sat = (rank_reg > 3'(MAX_RANK)) ? 3'(MAX_RANK) : rank_reg;

    always_comb
    begin
        for (int d = 0; d < MAX_RANK; d++)
        begin
            if (DIM_BITS * d + DIM_BITS <= 48)
                size_of[d] = sizes_reg[DIM_BITS*d +: DIM_BITS];
            else
                size_of[d] = '0;
            stride_of[d] = strides_all[96*(d/2) + STRIDE_BITS*(d%2) +: STRIDE_BITS];
        end
    end

    // Chain of dimension units, innermost dimension first.
    logic                 cv [MAX_RANK+1];
    logic [31:0]          cr [MAX_RANK+1];
    logic [31:0]          ca [MAX_RANK+1];
    logic                 cb [MAX_RANK+1];

    assign cv[0] = start && !busy;
    assign cr[0] = flat_index;
    assign ca[0] = base_reg;
    assign cb[0] = 1'b0;

    generate
        for (genvar k = 0; k < MAX_RANK; k++)
        begin : g_dim
            // Unit k handles dimension rank-1-k when it lies in the rank.
            localparam int D = MAX_RANK - 1 - k;
            logic act;
            logic [DIM_BITS-1:0] usz;
            logic [STRIDE_BITS-1:0] ust;
            logic [2:0] dsel;
            always_comb
            begin
                dsel = 3'(D);
                act  = 1'b0;
                usz  = '1;
                ust  = '0;
                // Dimension processed k-th is rank-1-k.
                for (int j = 0; j < MAX_RANK; j++)
                begin
                    if ((3'(j) + 3'(k) + 3'd1) == rank_sat)
                    begin
                        act = 1'b1;
                        usz = size_of[j];
                        ust = stride_of[j];
                    end
                end
            end
            logic gated_bad;
            assign gated_bad = cb[k];
            sta_divstage #(
                .DIM_BITS(DIM_BITS),
                .STRIDE_BITS(STRIDE_BITS)
            ) u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_valid (cv[k]),
                .in_active(act && !gated_bad && (dsel <= 3'd7)),
                .in_rest  (cr[k]),
                .in_addr  (ca[k]),
                .in_bad   (gated_bad),
                .in_size  (usz),
                .in_stride(ust),
                .out_valid(cv[k+1]),
                .out_rest (cr[k+1]),
                .out_addr (ca[k+1]),
                .out_bad  (cb[k+1])
            );
        end
    endgenerate

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cv[MAX_RANK];
        end
    end

    always_ff @(posedge clk)
    begin
        element_address <= cb[MAX_RANK] ? 32'd0 : ca[MAX_RANK];
        bad_shape       <= cb[MAX_RANK];
    end

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_shape |-> element_address == 32'd0)
        else $error("bad shape with nonzero address");
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule
